>>> sv/cmt_pkg.sv
// ---------------------------------------------------------------------------
// Cone mesh tessellator package
// Shared constants, register codes and pipeline tag types.
// ---------------------------------------------------------------------------
package cmt_pkg;

  localparam int ANG_BITS     = 24;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_GAIN  = 10188014;
  localparam int XY_W         = 27;
  localparam int Z_W          = 25;
  localparam int DIV_NW       = 33;
  localparam int DIV_DW       = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [15:0] RADIUS_RST = 16'd256;
  localparam logic [15:0] HEIGHT_RST = 16'd256;
  localparam logic [8:0]  SLICES_RST = 9'd16;
  localparam logic [8:0]  STACKS_RST = 9'd8;

  // arctangent steps in 2^-24 turn
  localparam logic [21:0] ARC_TAB [CORDIC_STEPS] = '{
    22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
    22'd166669,  22'd83416,   22'd41718,  22'd20860,
    22'd10430,   22'd5215,    22'd2608,   22'd1304,
    22'd652,     22'd326,     22'd163,    22'd81
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_SLICES = 3'd2,
    CFG_STACKS = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic side;
    logic bad;
  } item_tag_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic err;
  } vtx_tag_t;

endpackage

>>> sv/cone_mesh_tessellator.sv
// New requests may be taken while earlier ones are still in the pipeline;
// busy_o spaces them by the vertex count of each (error, base wedge, side cell),
// set by the single result port emitting one vertex per cycle.
// Results appear on consecutive cycles; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) restores the register defaults and empties
// the pipeline; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Cone mesh tessellator
// Deep pipeline: request check, ratio products, bit-per-stage dividers for
// slice phase and ring radius/height, 16 stage CORDIC per angle, trig rounding,
// then a vertex sequencer, multiply and rounding stages.
// ---------------------------------------------------------------------------
module cone_mesh_tessellator #(
  parameter int MAX_SLICES = 256,
  parameter int MAX_STACKS = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cmt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cmt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            req_type_i,
  input  logic [7:0]                      stack_index_i,
  input  logic [7:0]                      slice_index_i,
  output logic                            vert_valid_o,
  output logic signed [16:0]              vert_x_o,
  output logic [15:0]                     vert_y_o,
  output logic signed [16:0]              vert_z_o,
  output logic                            last_vertex_o,
  output logic                            index_error_o
);
  import cmt_pkg::*;

  localparam int TRIG_W  = FRAC_BITS + 2;
  localparam int TRIG_SH = ANG_BITS - FRAC_BITS;
  localparam int TRIG_RND = 1 << (TRIG_SH - 1);
  localparam int TRIG_LIM = 1 << FRAC_BITS;
  localparam int PW      = 17 + TRIG_W;
  localparam int OUT_RND = 1 << (FRAC_BITS - 1);
  localparam int TAG_N   = 3 + DIV_NW + CORDIC_STEPS;
  localparam int RD      = CORDIC_STEPS + 1;

  // ---------------------------------------------------------------- config
  logic [15:0] cone_radius_q, cone_height_q;
  logic [8:0]  slice_count_q, stack_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cone_radius_q <= RADIUS_RST;
      cone_height_q <= HEIGHT_RST;
      slice_count_q <= SLICES_RST;
      stack_count_q <= STACKS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RADIUS: cone_radius_q <= cfg_data_i;
        CFG_HEIGHT: cone_height_q <= cfg_data_i;
        CFG_SLICES: slice_count_q <= cfg_data_i[8:0];
        CFG_STACKS: stack_count_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- request intake
  // Check indices at acceptance; the check fixes how many vertices follow,
  // which sets how long to hold busy.
  logic       accept, bad_slices, bad_stacks, req_bad;
  logic [2:0] gap_q, gap_d;

  assign accept     = start_i && !busy_o;
  assign bad_slices = (slice_count_q == 9'd0) || (32'(slice_count_q) > 32'(MAX_SLICES)) ||
                      ({1'b0, slice_index_i} >= slice_count_q);
  assign bad_stacks = (stack_count_q == 9'd0) || (32'(stack_count_q) > 32'(MAX_STACKS)) ||
                      ({1'b0, stack_index_i} >= stack_count_q);
  assign req_bad    = bad_slices || (req_type_i && bad_stacks);

  always_comb begin
    gap_d = gap_q;
    if (accept) begin
      gap_d = req_bad ? 3'd0 : (req_type_i ? 3'd5 : 3'd2);
    end else if (gap_q != 3'd0) begin
      gap_d = gap_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 3'd0;
    end else begin
      gap_q <= gap_d;
    end
  end

  assign busy_o = gap_q != 3'd0;

  // Tag line: valid, type and error travel alongside the payload stages.
  item_tag_t tag_q [TAG_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAG_N; k++) begin
        tag_q[k] <= '0;
      end
    end else begin
      tag_q[0] <= '{valid: accept, side: req_type_i, bad: req_bad};
      for (int k = 1; k < TAG_N; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  logic [7:0] s0_i_q, s0_j_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_i_q <= stack_index_i;
      s0_j_q <= slice_index_i;
    end
  end

  // ------------------------------------------------ products for dividers
  function automatic logic [DIV_NW-1:0] ratio_num(input logic [15:0] value,
                                                  input logic [8:0]  num,
                                                  input logic [8:0]  den);
    logic [24:0] p;
    p = 25'(value) * 25'(num);
    return DIV_NW'({p, 1'b0}) + DIV_NW'(den);
  endfunction

  logic [DIV_NW-1:0] ph_a_q, ph_b_q, nr1_q, nr2_q, ny1_q, ny2_q;
  logic [DIV_DW-1:0] den_ph_q, den_rt_q;
  logic [8:0]        s0_i9, s0_j9;

  assign s0_i9 = {1'b0, s0_i_q};
  assign s0_j9 = {1'b0, s0_j_q};

  always_ff @(posedge clk_i) begin
    ph_a_q   <= DIV_NW'(s0_j9) << ANG_BITS;
    ph_b_q   <= DIV_NW'(s0_j9 + 9'd1) << ANG_BITS;
    nr1_q    <= ratio_num(cone_radius_q, stack_count_q - s0_i9, stack_count_q);
    nr2_q    <= ratio_num(cone_radius_q, stack_count_q - s0_i9 - 9'd1, stack_count_q);
    ny1_q    <= ratio_num(cone_height_q, s0_i9, stack_count_q);
    ny2_q    <= ratio_num(cone_height_q, s0_i9 + 9'd1, stack_count_q);
    den_ph_q <= DIV_DW'(slice_count_q);
    den_rt_q <= DIV_DW'({stack_count_q, 1'b0});
  end

  // --------------------------------------------------------------- dividers
  logic [DIV_NW-1:0] q_ph [2];
  logic [DIV_NW-1:0] q_rt [4];
  logic [DIV_NW-1:0] n_rt [4];

  assign n_rt[0] = nr1_q;
  assign n_rt[1] = nr2_q;
  assign n_rt[2] = ny1_q;
  assign n_rt[3] = ny2_q;

  cmt_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_pa (
    .clk_i(clk_i), .num_i(ph_a_q), .den_i(den_ph_q), .quo_o(q_ph[0])
  );
  cmt_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_pb (
    .clk_i(clk_i), .num_i(ph_b_q), .den_i(den_ph_q), .quo_o(q_ph[1])
  );

  for (genvar r = 0; r < 4; r++) begin : g_rt
    cmt_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_rt (
      .clk_i(clk_i), .num_i(n_rt[r]), .den_i(den_rt_q), .quo_o(q_rt[r])
    );
  end

  // Hold ring radii and heights while CORDIC and rounding run.
  logic [15:0] rdly_q [4][RD];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      rdly_q[r][0] <= q_rt[r][15:0];
      for (int m = 1; m < RD; m++) begin
        rdly_q[r][m] <= rdly_q[r][m-1];
      end
    end
  end

  // ----------------------------------------------------------------- CORDIC
  // Lane 0 is angle j, lane 1 angle j+1; the phase wraps modulo one turn.
  logic signed [XY_W-1:0] cx_q [2][CORDIC_STEPS];
  logic signed [XY_W-1:0] cy_q [2][CORDIC_STEPS];
  logic signed [Z_W-1:0]  cz_q [2][CORDIC_STEPS];
  logic [1:0]             cq_q [2][CORDIC_STEPS];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [XY_W-1:0] x_in, y_in;
      logic signed [Z_W-1:0]  z_in;
      logic [1:0]             q_in;

      if (k == 0) begin : g_first
        assign x_in = XY_W'(CORDIC_GAIN);
        assign y_in = '0;
        assign z_in = Z_W'(q_ph[l][ANG_BITS-3:0]);
        assign q_in = q_ph[l][ANG_BITS-1:ANG_BITS-2];
      end else begin : g_next
        assign x_in = cx_q[l][k-1];
        assign y_in = cy_q[l][k-1];
        assign z_in = cz_q[l][k-1];
        assign q_in = cq_q[l][k-1];
      end

      always_ff @(posedge clk_i) begin
        if (!z_in[Z_W-1]) begin
          cx_q[l][k] <= x_in - (y_in >>> k);
          cy_q[l][k] <= y_in + (x_in >>> k);
          cz_q[l][k] <= z_in - Z_W'(ARC_TAB[k]);
        end else begin
          cx_q[l][k] <= x_in + (y_in >>> k);
          cy_q[l][k] <= y_in - (x_in >>> k);
          cz_q[l][k] <= z_in + Z_W'(ARC_TAB[k]);
        end
        cq_q[l][k] <= q_in;
      end
    end
  end

  // Round half away from zero to FRAC_BITS and clamp to one.
  function automatic logic signed [TRIG_W-1:0] trig_round(input logic signed [XY_W-1:0] v);
    logic [XY_W-1:0] mag;
    logic [XY_W-1:0] rv;
    mag = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
    rv  = (mag + XY_W'(TRIG_RND)) >> TRIG_SH;
    if (rv > XY_W'(TRIG_LIM)) begin
      rv = XY_W'(TRIG_LIM);
    end
    return v[XY_W-1] ? TRIG_W'(-rv) : TRIG_W'(rv);
  endfunction

  logic signed [TRIG_W-1:0] tc_q [2];
  logic signed [TRIG_W-1:0] ts_q [2];

  for (genvar l = 0; l < 2; l++) begin : g_trig
    logic signed [TRIG_W-1:0] c_r, s_r;

    assign c_r = trig_round(cx_q[l][CORDIC_STEPS-1]);
    assign s_r = trig_round(cy_q[l][CORDIC_STEPS-1]);

    always_ff @(posedge clk_i) begin
      case (cq_q[l][CORDIC_STEPS-1])
        2'd0: begin tc_q[l] <= c_r;  ts_q[l] <= s_r;  end
        2'd1: begin tc_q[l] <= -s_r; ts_q[l] <= c_r;  end
        2'd2: begin tc_q[l] <= -c_r; ts_q[l] <= -s_r; end
        default: begin tc_q[l] <= s_r; ts_q[l] <= -c_r; end
      endcase
    end
  end

  // -------------------------------------------------------- vertex sequencer
  // Requests are spaced by at least their vertex count, so a new one lands no earlier
  // than the previous one issues its last vertex, and exactly then when back to back.
  logic                     arrive;
  logic                     emit_act_q, h_side_q, h_bad_q;
  logic [2:0]               emit_idx_q;
  logic [15:0]              h_r1_q, h_r2_q, h_y1_q, h_y2_q;
  logic signed [TRIG_W-1:0] h_ca_q, h_sa_q, h_cb_q, h_sb_q;

  assign arrive = tag_q[TAG_N-1].valid;

  vtx_tag_t                 sel_tag;
  logic [15:0]              sel_r, sel_y;
  logic signed [TRIG_W-1:0] sel_c, sel_s;

  always_comb begin
    sel_tag = '{valid: emit_act_q, last: 1'b0, err: 1'b0};
    sel_r   = '0;
    sel_y   = '0;
    sel_c   = h_ca_q;
    sel_s   = h_sa_q;
    if (h_bad_q) begin
      sel_tag.last = 1'b1;
      sel_tag.err  = 1'b1;
    end else if (h_side_q) begin
      // p1, p2, p3, p1, p3, p4
      case (emit_idx_q)
        3'd0: begin sel_r = h_r1_q; sel_y = h_y1_q; end
        3'd1: begin sel_r = h_r2_q; sel_y = h_y2_q; end
        3'd2: begin sel_r = h_r2_q; sel_y = h_y2_q; sel_c = h_cb_q; sel_s = h_sb_q; end
        3'd3: begin sel_r = h_r1_q; sel_y = h_y1_q; end
        3'd4: begin sel_r = h_r2_q; sel_y = h_y2_q; sel_c = h_cb_q; sel_s = h_sb_q; end
        default: begin
          sel_r = h_r1_q; sel_y = h_y1_q; sel_c = h_cb_q; sel_s = h_sb_q;
          sel_tag.last = 1'b1;
        end
      endcase
    end else begin
      // centre, rim at j, rim at j+1
      case (emit_idx_q)
        3'd0: ;
        3'd1: sel_r = cone_radius_q;
        default: begin
          sel_r = cone_radius_q; sel_c = h_cb_q; sel_s = h_sb_q;
          sel_tag.last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_act_q <= 1'b0;
      emit_idx_q <= 3'd0;
    end else if (arrive) begin
      emit_act_q <= 1'b1;
      emit_idx_q <= 3'd0;
    end else if (emit_act_q) begin
      emit_act_q <= !sel_tag.last;
      emit_idx_q <= emit_idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (arrive) begin
      h_side_q <= tag_q[TAG_N-1].side;
      h_bad_q  <= tag_q[TAG_N-1].bad;
      h_r1_q   <= rdly_q[0][RD-1];
      h_r2_q   <= rdly_q[1][RD-1];
      h_y1_q   <= rdly_q[2][RD-1];
      h_y2_q   <= rdly_q[3][RD-1];
      h_ca_q   <= tc_q[0];
      h_sa_q   <= ts_q[0];
      h_cb_q   <= tc_q[1];
      h_sb_q   <= ts_q[1];
    end
  end

  // ------------------------------------------------ multiply and rounding
  vtx_tag_t                 sel_tag_q, mul_tag_q;
  logic [15:0]              sel_r_q, sel_y_q, mul_y_q;
  logic signed [TRIG_W-1:0] sel_c_q, sel_s_q;
  logic signed [PW-1:0]     mx_q, mz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_tag_q    <= '0;
      mul_tag_q    <= '0;
      vert_valid_o <= 1'b0;
    end else begin
      sel_tag_q    <= sel_tag;
      mul_tag_q    <= sel_tag_q;
      vert_valid_o <= mul_tag_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_r_q <= sel_r;
    sel_y_q <= sel_y;
    sel_c_q <= sel_c;
    sel_s_q <= sel_s;
    mx_q    <= PW'($signed({1'b0, sel_r_q})) * PW'(sel_c_q);
    mz_q    <= PW'($signed({1'b0, sel_r_q})) * PW'(sel_s_q);
    mul_y_q <= sel_y_q;
  end

  logic [PW-1:0] ax, az, rx, rz;

  always_comb begin
    ax = mx_q[PW-1] ? PW'(-mx_q) : PW'(mx_q);
    az = mz_q[PW-1] ? PW'(-mz_q) : PW'(mz_q);
    rx = (ax + PW'(OUT_RND)) >> FRAC_BITS;
    rz = (az + PW'(OUT_RND)) >> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    vert_x_o      <= mx_q[PW-1] ? 17'(-rx) : 17'(rx);
    vert_z_o      <= mz_q[PW-1] ? 17'(-rz) : 17'(rz);
    vert_y_o      <= mul_y_q;
    last_vertex_o <= mul_tag_q.last;
    index_error_o <= mul_tag_q.err;
  end

`ifndef SYNTHESIS
  // an error result is always alone and all zero
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_valid_o && index_error_o |-> last_vertex_o)
    else $error("error result without last_vertex");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_valid_o && index_error_o |-> vert_x_o == 17'd0 && vert_y_o == 16'd0 &&
    vert_z_o == 17'd0)
    else $error("error result with nonzero coordinates");

  // a new request reaches the sequencer only when it is idle or the previous one finishes
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arrive |-> !emit_act_q || sel_tag.last)
    else $error("vertex sequencer overrun");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(accept))
    else $error("busy raised without an accepted transaction");
`endif

endmodule

>>> sv/cmt_div.sv
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, NW stages, unsigned operands.
// ---------------------------------------------------------------------------
module cmt_div #(
  parameter int NW = 33,
  parameter int DW = 10
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, num_in[NW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      num_q[k] <= {num_in[NW-2:0], 1'b0};
      quo_q[k] <= {quo_in[NW-2:0], ge};
      rem_q[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
      den_q[k] <= den_in;
    end
  end

  assign quo_o = quo_q[NW-1];

endmodule

>>> tb/cone_mesh_tessellator_tb.sv
// ---------------------------------------------------------------------------
// Cone mesh tessellator testbench
// Drives base wedge and side cell requests under several register settings,
// predicts every vertex with an independent CORDIC and ring model, and checks
// each strobed vertex in order against the predicted stream.
// ---------------------------------------------------------------------------
module cone_mesh_tessellator_tb;
  import cmt_pkg::*;

  localparam int FRAC = 8;
  localparam int LATENCY = 55;

  typedef struct {
    logic       side;
    logic [7:0] stack;
    logic [7:0] slice;
  } cell_req_t;

  typedef struct {
    logic signed [16:0] x;
    logic [15:0]        y;
    logic signed [16:0] z;
    logic               last;
    logic               err;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic req_type_i = 1'b0;
  logic [7:0] stack_index_i = '0;
  logic [7:0] slice_index_i = '0;
  logic vert_valid_o;
  logic signed [16:0] vert_x_o;
  logic [15:0] vert_y_o;
  logic signed [16:0] vert_z_o;
  logic last_vertex_o;
  logic index_error_o;

  cone_mesh_tessellator i_dut (.*);

  always #1 clk_i = ~clk_i;

  // shadow registers of the predictor
  int unsigned mdl_radius, mdl_height, mdl_slices, mdl_stacks;

  cell_req_t pending_reqs[$];
  vertex_t   expected_verts[$];
  int        fail_count = 0;
  int        vert_count = 0;
  int        err_count = 0;
  int        req_count = 0;
  bit        quiet_phase = 0;  // no idling while set

  function automatic longint floor_sh(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_sh(longint v, int n);
    longint mag;
    if (n == 0) return v;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp_trig(longint v);
    longint r;
    r = round_sh(v, ANG_BITS - FRAC);
    if (r > (1 << FRAC)) r = 1 << FRAC;
    if (r < -(1 << FRAC)) r = -(1 << FRAC);
    return r;
  endfunction

  // cosine and sine of slice angle j
  task automatic angle_trig(input int unsigned j, output longint cs, output longint sn);
    longint unsigned phase;
    int quad;
    longint z, x, y, nx, ny, c, s;
    phase = ((longint'(j) << ANG_BITS) / mdl_slices) & 64'hFFFFFF;
    quad = (phase >> (ANG_BITS - 2)) & 3;
    z = phase & 64'h3FFFFF;
    x = CORDIC_GAIN;
    y = 0;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (z >= 0) begin
        nx = x - floor_sh(y, k); ny = y + floor_sh(x, k); z -= ARC_TAB[k];
      end else begin
        nx = x + floor_sh(y, k); ny = y - floor_sh(x, k); z += ARC_TAB[k];
      end
      x = nx; y = ny;
    end
    c = clamp_trig(x);
    s = clamp_trig(y);
    case (quad)
      0: begin cs = c; sn = s; end
      1: begin cs = -s; sn = c; end
      2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
  endtask

  function automatic int unsigned scaled(int unsigned v, int unsigned num, int unsigned den);
    longint unsigned p;
    p = longint'(v) * num * 2 + den;
    return p / (longint'(den) * 2);
  endfunction

  task automatic push_vertex(longint x, int unsigned y, longint z, bit last, bit err);
    vertex_t v;
    v.x = x[16:0]; v.y = y[15:0]; v.z = z[16:0]; v.last = last; v.err = err;
    expected_verts.insert(expected_verts.size(), v);
  endtask

  task automatic push_ring(int unsigned r, int unsigned y, longint cs, longint sn, bit last);
    push_vertex(round_sh(longint'(r) * cs, FRAC), y, round_sh(longint'(r) * sn, FRAC),
                last, 1'b0);
  endtask

  // expand one accepted request into its vertex stream
  task automatic predict_cell(cell_req_t q);
    bit bad;
    longint ca, sa, cb, sb;
    int unsigned r1, r2, y1, y2, i;
    i = q.stack;
    bad = mdl_slices == 0 || mdl_slices > 256 || q.slice >= mdl_slices;
    if (q.side) bad = bad || mdl_stacks == 0 || mdl_stacks > 256 || i >= mdl_stacks;
    if (bad) begin
      push_vertex(0, 0, 0, 1, 1);
      return;
    end
    angle_trig(q.slice, ca, sa);
    angle_trig(q.slice + 1, cb, sb);
    if (!q.side) begin
      push_vertex(0, 0, 0, 0, 0);
      push_ring(mdl_radius, 0, ca, sa, 0);
      push_ring(mdl_radius, 0, cb, sb, 1);
    end else begin
      r1 = scaled(mdl_radius, mdl_stacks - i, mdl_stacks);
      r2 = scaled(mdl_radius, mdl_stacks - i - 1, mdl_stacks);
      y1 = scaled(mdl_height, i, mdl_stacks);
      y2 = scaled(mdl_height, i + 1, mdl_stacks);
      push_ring(r1, y1, ca, sa, 0);
      push_ring(r2, y2, ca, sa, 0);
      push_ring(r2, y2, cb, sb, 0);
      push_ring(r1, y1, ca, sa, 0);
      push_ring(r2, y2, cb, sb, 0);
      push_ring(r1, y1, cb, sb, 1);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at vertex %0d: %s got %0d expected %0d", vert_count, what, got, want);
    fail_count++;
  endtask

  // driver: present the head of the pending queue at the falling edge, idle at random;
  // the monitor drops the head once its transaction is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pending_reqs.size() > 0 && (quiet_phase || $urandom_range(99) >= 36)) begin
        cell_req_t q;
        q = pending_reqs[0];
        start_i <= 1'b1;
        req_type_i <= q.side;
        stack_index_i <= q.stack;
        slice_index_i <= q.slice;
      end else begin
        start_i <= 1'b0;
        req_type_i <= $urandom_range(1);
        stack_index_i <= $urandom_range(255);
        slice_index_i <= $urandom_range(255);
      end
    end
  end

  // monitor: take accepted requests and check strobed vertices at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_cell(pending_reqs.pop_front());
        req_count++;
      end
      if (vert_valid_o) begin
        if (expected_verts.size() == 0) begin
          report_mismatch("unexpected vertex, pending predictions", 1, 0);
        end else begin
          vertex_t e;
          e = expected_verts.pop_front();
          if (vert_x_o !== e.x) report_mismatch("vert_x", vert_x_o, e.x);
          if (vert_y_o !== e.y) report_mismatch("vert_y", vert_y_o, e.y);
          if (vert_z_o !== e.z) report_mismatch("vert_z", vert_z_o, e.z);
          if (last_vertex_o !== e.last) report_mismatch("last_vertex", last_vertex_o, e.last);
          if (index_error_o !== e.err) report_mismatch("index_error", index_error_o, e.err);
          if (e.err) err_count++;
        end
        vert_count++;
      end
    end
  end

  // register write while the block is idle; the shadow copy follows it
  task automatic write_reg(int idx, int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx[CFG_IDX_W-1:0];
    cfg_data_i <= val[15:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_RADIUS: mdl_radius = val & 16'hFFFF;
      CFG_HEIGHT: mdl_height = val & 16'hFFFF;
      CFG_SLICES: mdl_slices = val & 9'h1FF;
      CFG_STACKS: mdl_stacks = val & 9'h1FF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i <= $urandom_range(16'hFFFF);
  endtask

  // hold until all queued requests are taken and every vertex has arrived
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_verts.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic add_req(bit side, int stack, int slice);
    cell_req_t q;
    q.side = side; q.stack = stack[7:0]; q.slice = slice[7:0];
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  // mostly in-range cells, with some out-of-range noise
  task automatic add_random(int n);
    int s, t;
    for (int k = 0; k < n; k++) begin
      s = (mdl_slices > 256 || mdl_slices == 0) ? 256 : mdl_slices;
      t = (mdl_stacks > 256 || mdl_stacks == 0) ? 256 : mdl_stacks;
      if ($urandom_range(99) < 80)
        add_req($urandom_range(1), $urandom_range(t - 1), $urandom_range(s - 1));
      else
        add_req($urandom_range(1), $urandom_range(255), $urandom_range(255));
    end
  endtask

  task automatic set_cone(int unsigned r, int unsigned h, int unsigned sl, int unsigned st);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_SLICES, sl);
    write_reg(CFG_STACKS, st);
  endtask

  initial begin
    mdl_radius = RADIUS_RST; mdl_height = HEIGHT_RST;
    mdl_slices = SLICES_RST; mdl_stacks = STACKS_RST;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, both request kinds, wrap, extremes, errors
    add_req(0, 0, 0);
    add_req(0, 200, 15);
    add_req(1, 0, 0);
    add_req(1, 7, 15);
    add_req(1, 8, 3);
    add_req(0, 0, 16);
    add_req(1, 255, 255);
    add_req(1, 3, 9);
    drain();
    write_reg(7, 16'h1234);  // unused index, must change nothing
    write_reg(4, 16'hFFFF);
    add_req(1, 2, 5);
    add_req(0, 0, 15);
    drain();
    set_cone(16'hFFFF, 16'hFFFF, 256, 256);
    add_req(1, 255, 255);
    add_req(1, 0, 0);
    add_req(0, 0, 255);
    add_req(1, 128, 64);
    drain();
    set_cone(0, 0, 1, 1);
    add_req(0, 0, 0);
    add_req(1, 0, 0);
    add_req(1, 1, 0);
    drain();
    set_cone(300, 500, 0, 0);
    add_req(0, 0, 0);
    add_req(1, 0, 0);
    drain();
    set_cone(1000, 1000, 511, 257);
    add_req(0, 0, 0);
    add_req(1, 0, 0);
    drain();

    // random phases with several settings; one long stretch without idling
    for (int ph = 0; ph < 6; ph++) begin
      set_cone($urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
               (ph == 2) ? 3 : $urandom_range(1, 256), (ph == 3) ? 256 : $urandom_range(1, 256));
      quiet_phase = (ph == 4);
      add_random(75);
      drain();
    end
    quiet_phase = 0;
    $display("covered %0d requests and %0d vertices, %0d of them index errors",
             req_count, vert_count, err_count);
    if (fail_count == 0) begin
      $display("cone_mesh_tessellator test passed");
    end else begin
      $display("cone_mesh_tessellator test failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #400000;
    $display("cone_mesh_tessellator test failed");
    $finish;
  end

endmodule
